// ===== rtl/amix_pkg.sv =====
package amix_pkg;

	localparam int SampleW       = 16;
	localparam int GainW         = 17;
	localparam int RecoveryShift = 5;
	localparam int MulSteps      = GainW;
	localparam int DivSteps      = SampleW;

	localparam logic [GainW-1:0]   GainUnity  = 17'h10000;
	localparam logic [GainW-1:0]   LimitHiMag = 17'd32767;
	localparam logic [GainW-1:0]   LimitLoMag = 17'd32768;
	localparam logic [SampleW-1:0] ClampHi    = 16'h7FFF;
	localparam logic [SampleW-1:0] ClampLo    = 16'h8000;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ===== rtl/amix_mul.sv =====
// bit-serial |sum| * gain, one gain bit per cycle, returns (product >> 16)
module amix_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [amix_pkg::GainW-1:0]     mag,
	input  logic [amix_pkg::GainW-1:0]     gain,
	output amix_pkg::unit_stat_t           stat,
	output logic [amix_pkg::GainW-1:0]     smag
);

	localparam int CntW = $clog2(amix_pkg::MulSteps);

	logic [amix_pkg::GainW-1:0] hi_q;
	logic [amix_pkg::GainW-1:0] lo_q;
	logic [amix_pkg::GainW-1:0] mag_q;
	logic [CntW-1:0]            cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [amix_pkg::GainW:0]   acc;

	assign acc = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mag_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(amix_pkg::MulSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q  <= '0;
			lo_q  <= gain;
			mag_q <= mag;
		end else if (busy_q) begin
			hi_q <= acc[amix_pkg::GainW:1];
			lo_q <= {acc[0], lo_q[amix_pkg::GainW-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign smag      = {hi_q[amix_pkg::GainW-2:0], lo_q[amix_pkg::GainW-1]};

endmodule

// ===== rtl/amix_div.sv =====
// restoring divide (num << 16) / den, one quotient bit per cycle; needs num < den
module amix_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [amix_pkg::GainW-1:0]       num,
	input  logic [amix_pkg::GainW-1:0]       den,
	output amix_pkg::unit_stat_t             stat,
	output logic [amix_pkg::SampleW-1:0]     quo
);

	localparam int CntW = $clog2(amix_pkg::DivSteps);

	logic [amix_pkg::GainW-1:0]   rem_q;
	logic [amix_pkg::GainW-1:0]   den_q;
	logic [amix_pkg::SampleW-1:0] quo_q;
	logic [CntW-1:0]              cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [amix_pkg::GainW:0]     rem2;
	logic [amix_pkg::GainW:0]     diff;
	logic                         ge;

	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(amix_pkg::DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[amix_pkg::GainW-1:0] : rem2[amix_pkg::GainW-1:0];
			quo_q <= {quo_q[amix_pkg::SampleW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

// ===== rtl/adaptive_gain_audio_mixer_core.sv =====
// channel | dir | tdata                               | tuser
// s_      | in  | [15:0] new_sample, [31:16] base_sample | block_start
// m_      | out | [15:0] mixed_sample                 | clipped
//
// One word at a time: a bit-serial gain multiply, plus a restoring divide
// for the new gain when the scaled result clips.
// s_tready is high only while no word is in work; the result register lets
// the next word in while m_ waits.
// Reset sets the gain to unity; no clearing pass.
module adaptive_gain_audio_mixer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // new_sample, base_sample
	input  logic                s_tuser,   // block_start
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // mixed_sample
	output logic                m_tuser    // clipped
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_REC,
		ST_OUT
	} state_t;

	state_t                         state_q;
	logic [amix_pkg::GainW-1:0]     gain_q;
	logic                           neg_q;
	logic                           clip_q;
	logic [amix_pkg::SampleW-1:0]   res_q;
	logic [amix_pkg::SampleW-1:0]   m_data_q;
	logic                           m_user_q;
	logic                           m_valid_q;

	logic [amix_pkg::SampleW-1:0]   new_s;
	logic [amix_pkg::SampleW-1:0]   base_s;
	logic [amix_pkg::GainW-1:0]     sum;
	logic [amix_pkg::GainW-1:0]     mag;
	logic [amix_pkg::GainW-1:0]     gain_eff;
	logic                           in_acc;
	logic                           mul_start;
	logic                           div_start;
	amix_pkg::unit_stat_t           mul_stat;
	amix_pkg::unit_stat_t           div_stat;
	logic [amix_pkg::GainW-1:0]     smag;
	logic [amix_pkg::SampleW-1:0]   quo;
	logic                           ovf_pos;
	logic                           ovf_neg;
	logic [amix_pkg::GainW-1:0]     shortfall;

	assign new_s    = s_tdata[15:0];
	assign base_s   = s_tdata[31:16];
	assign sum      = {new_s[15], new_s} + {base_s[15], base_s};
	assign mag      = sum[amix_pkg::GainW-1] ? (~sum + 1'b1) : sum;
	assign gain_eff = s_tuser ? amix_pkg::GainUnity : gain_q;
	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	assign ovf_pos   = !neg_q && (smag > amix_pkg::LimitHiMag);
	assign ovf_neg   = neg_q && (smag > amix_pkg::LimitLoMag);
	assign mul_start = in_acc;
	assign div_start = (state_q == ST_CHK) && (ovf_pos || ovf_neg);
	assign shortfall = amix_pkg::GainUnity - gain_q;

	amix_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mag    (mag),
		.gain   (gain_eff),
		.stat   (mul_stat),
		.smag   (smag)
	);

	amix_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ovf_neg ? amix_pkg::LimitLoMag : amix_pkg::LimitHiMag),
		.den    (smag),
		.stat   (div_stat),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			gain_q    <= amix_pkg::GainUnity;
			m_valid_q <= 1'b0;
			neg_q     <= 1'b0;
			clip_q    <= 1'b0;
			res_q     <= '0;
			m_data_q  <= '0;
			m_user_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						gain_q  <= gain_eff;
						neg_q   <= sum[amix_pkg::GainW-1];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					clip_q <= ovf_pos || ovf_neg;
					if (ovf_pos) begin
						res_q   <= amix_pkg::ClampHi;
						state_q <= ST_DIV;
					end else if (ovf_neg) begin
						res_q   <= amix_pkg::ClampLo;
						state_q <= ST_DIV;
					end else begin
						res_q   <= neg_q ? (~smag[15:0] + 1'b1) : smag[15:0];
						state_q <= ST_REC;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						gain_q  <= {1'b0, quo};
						state_q <= ST_REC;
					end
				end
				ST_REC: begin
					if (gain_q < amix_pkg::GainUnity) begin
						gain_q <= gain_q + (shortfall >> amix_pkg::RecoveryShift);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= res_q;
						m_user_q  <= clip_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_q >= amix_pkg::LimitHiMag) && (gain_q <= amix_pkg::GainUnity))
		else $error("gain out of range");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == amix_pkg::ClampHi || m_tdata == amix_pkg::ClampLo))
		else $error("clipped word not at a limit");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_MUL))
		else $error("multiply done outside multiply state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV && clip_q))
		else $error("divide done without clip");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(mul_stat.busy || div_stat.busy))
		else $error("arithmetic unit busy while idle");

endmodule
